[rtl/core/crtd_pkg.sv]
`timescale 1ns / 1ps
// Package for the character reference text decoder: scan modes, byte codes,
// state and burst types, the control remap table and UTF-8 encoding helpers.
package crtd_pkg;

   localparam logic [2:0] MODE_TEXT   = 3'd0;
   localparam logic [2:0] MODE_AMP    = 3'd1;
   localparam logic [2:0] MODE_HASH   = 3'd2;
   localparam logic [2:0] MODE_HASHX  = 3'd3;
   localparam logic [2:0] MODE_DIGITS = 3'd4;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_LF   = 8'h0a;
   localparam logic [7:0] CH_CR   = 8'h0d;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3b;
   localparam logic [7:0] CH_UX   = 8'h58;
   localparam logic [7:0] CH_LX   = 8'h78;

   localparam int          CP_W      = 21;
   localparam int          BURST_N   = 8;
   localparam int          CODE_MAX  = 32'h10ffff;
   localparam logic [20:0] CP_MAX    = 21'(CODE_MAX);
   localparam logic [20:0] CP_REPL   = 21'h00fffd;
   localparam logic [20:0] SURR_LO   = 21'h00d800;
   localparam logic [20:0] SURR_HI   = 21'h00dfff;
   localparam logic [20:0] CTRL_LO   = 21'h000080;
   localparam logic [20:0] CTRL_HI   = 21'h00009f;
   localparam logic [20:0] DEC_BOUND = 21'(CODE_MAX / 10);
   localparam logic [20:0] HEX_BOUND = 21'(CODE_MAX / 16);

   typedef struct packed {
      logic [2:0]      mode;
      logic            hex;
      logic [CP_W-1:0] accum;
      logic            ovf;
      logic            after_cr;
   } crtd_state_type;

   typedef struct packed {
      logic [BURST_N-1:0][7:0] bytes;
      logic [3:0]              count;
   } crtd_burst_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } crtd_digit_type;

   function automatic logic [15:0] ctrl_map(input logic [4:0] idx);
      logic [15:0] v;
      case (idx)
         5'd0:    v = 16'h20ac;
         5'd1:    v = 16'h0081;
         5'd2:    v = 16'h201a;
         5'd3:    v = 16'h0192;
         5'd4:    v = 16'h201e;
         5'd5:    v = 16'h2026;
         5'd6:    v = 16'h2020;
         5'd7:    v = 16'h2021;
         5'd8:    v = 16'h02c6;
         5'd9:    v = 16'h2030;
         5'd10:   v = 16'h0160;
         5'd11:   v = 16'h2039;
         5'd12:   v = 16'h0152;
         5'd13:   v = 16'h008d;
         5'd14:   v = 16'h017d;
         5'd15:   v = 16'h008f;
         5'd16:   v = 16'h0090;
         5'd17:   v = 16'h2018;
         5'd18:   v = 16'h2019;
         5'd19:   v = 16'h201c;
         5'd20:   v = 16'h201d;
         5'd21:   v = 16'h2022;
         5'd22:   v = 16'h2013;
         5'd23:   v = 16'h2014;
         5'd24:   v = 16'h02dc;
         5'd25:   v = 16'h2122;
         5'd26:   v = 16'h0161;
         5'd27:   v = 16'h203a;
         5'd28:   v = 16'h0153;
         5'd29:   v = 16'h009d;
         5'd30:   v = 16'h017e;
         default: v = 16'h0178;
      endcase
      return v;
   endfunction

   function automatic crtd_digit_type digit_value(input logic [7:0] b, input logic hex);
      crtd_digit_type d;
      d = '0;
      if (b inside {[8'h30:8'h39]}) begin
         d.ok  = 1'b1;
         d.val = b[3:0];
      end else if (hex && (b inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
         d.ok  = 1'b1;
         d.val = 4'(b[2:0] + 4'd9);
      end
      return d;
   endfunction

   // Replace bad code points and remap the C1 control range.
   function automatic logic [CP_W-1:0] fix_code(input logic [CP_W-1:0] acc, input logic ovf);
      logic [CP_W-1:0] cp;
      if (ovf || acc == '0 || acc > CP_MAX || (acc >= SURR_LO && acc <= SURR_HI)) begin
         cp = CP_REPL;
      end else if (acc >= CTRL_LO && acc <= CTRL_HI) begin
         cp = {5'b0, ctrl_map(acc[4:0])};
      end else begin
         cp = acc;
      end
      return cp;
   endfunction

   function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
      logic [2:0] n;
      if (cp <= 21'h7f) begin
         n = 3'd1;
      end else if (cp <= 21'h7ff) begin
         n = 3'd2;
      end else if (cp <= 21'hffff) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] k);
      logic [7:0] v;
      logic [2:0] n;
      n = utf8_len(cp);
      v = 8'h00;
      case (n)
         3'd1: v = {1'b0, cp[6:0]};
         3'd2: begin
            case (k)
               2'd0:    v = {3'b110, cp[10:6]};
               default: v = {2'b10, cp[5:0]};
            endcase
         end
         3'd3: begin
            case (k)
               2'd0:    v = {4'b1110, cp[15:12]};
               2'd1:    v = {2'b10, cp[11:6]};
               default: v = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (k)
               2'd0:    v = {5'b11110, cp[20:18]};
               2'd1:    v = {2'b10, cp[17:12]};
               2'd2:    v = {2'b10, cp[11:6]};
               default: v = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return v;
   endfunction

endpackage

[rtl/core/crtd_req_if.sv]
`timescale 1ns / 1ps
// Input channel of the decoder: one raw text byte per word, with end flag.
// Stands alone; no package needed.
interface crtd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

[rtl/core/crtd_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the decoder: one UTF-8 byte or end marker per word.
// Stands alone; no package needed.
interface crtd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       text_end;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output text_end, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input text_end, output ready);
endinterface

[rtl/core/crtd_step.sv]
`timescale 1ns / 1ps
// Single-pass decode of one text byte: next scan state and the burst of bytes out.
// Depends on crtd_pkg.
module crtd_step (
   input  crtd_pkg::crtd_state_type cur,
   input  logic [7:0]               in_byte,
   input  logic                     is_last,
   output crtd_pkg::crtd_state_type nxt,
   output crtd_pkg::crtd_burst_type burst
);
   import crtd_pkg::*;

   crtd_digit_type  dig;
   logic            dig_hex;
   logic [CP_W-1:0] base;
   logic            base_ovf;
   logic [CP_W-1:0] bound;
   logic [CP_W-1:0] acc_new;
   logic            ovf_new;
   logic [CP_W-1:0] cp_old;
   logic [CP_W-1:0] cp_end;

   always_comb begin
      case (cur.mode)
         MODE_HASH:   dig_hex = 1'b0;
         MODE_HASHX:  dig_hex = 1'b1;
         default:     dig_hex = cur.hex;
      endcase
      dig = digit_value(in_byte, dig_hex);
      if (cur.mode == MODE_DIGITS) begin
         base     = cur.accum;
         base_ovf = cur.ovf;
      end else begin
         base     = '0;
         base_ovf = 1'b0;
      end
      bound = dig_hex ? HEX_BOUND : DEC_BOUND;
      if (base_ovf || base > bound) begin
         acc_new = base;
         ovf_new = 1'b1;
      end else if (dig_hex) begin
         acc_new = {base[16:0], 4'b0} + {17'b0, dig.val};
         ovf_new = 1'b0;
      end else begin
         acc_new = {base[17:0], 3'b0} + {base[19:0], 1'b0} + {17'b0, dig.val};
         ovf_new = 1'b0;
      end
      cp_old = fix_code(cur.accum, cur.ovf);
   end

   always_comb begin
      logic       tb;
      logic [2:0] n;
      nxt   = cur;
      burst = '0;
      tb    = 1'b0;
      n     = '0;
      cp_end = '0;
      case (cur.mode)
         MODE_AMP: begin
            if (in_byte == CH_HASH) begin
               nxt.mode = MODE_HASH;
            end else begin
               burst.bytes[burst.count[2:0]] = CH_AMP;
               burst.count = burst.count + 4'd1;
               nxt.mode = MODE_TEXT;
               tb = 1'b1;
            end
         end
         MODE_HASH: begin
            if (in_byte == CH_LX || in_byte == CH_UX) begin
               nxt.mode = MODE_HASHX;
               nxt.hex  = 1'b1;
            end else if (dig.ok) begin
               nxt.mode  = MODE_DIGITS;
               nxt.hex   = 1'b0;
               nxt.accum = acc_new;
               nxt.ovf   = ovf_new;
            end else begin
               burst.bytes[0] = CH_AMP;
               burst.bytes[1] = CH_HASH;
               burst.count = 4'd2;
               nxt.mode = MODE_TEXT;
               tb = 1'b1;
            end
         end
         MODE_HASHX: begin
            if (dig.ok) begin
               nxt.mode  = MODE_DIGITS;
               nxt.accum = acc_new;
               nxt.ovf   = ovf_new;
            end else begin
               burst.bytes[0] = CH_AMP;
               burst.bytes[1] = CH_HASH;
               burst.bytes[2] = CH_LX;
               burst.count = 4'd3;
               nxt.mode = MODE_TEXT;
               nxt.hex  = 1'b0;
               tb = 1'b1;
            end
         end
         MODE_DIGITS: begin
            if (dig.ok) begin
               nxt.accum = acc_new;
               nxt.ovf   = ovf_new;
            end else begin
               n = utf8_len(cp_old);
               for (int k = 0; k < 4; k++) begin
                  if (3'(k) < n) begin
                     burst.bytes[k] = utf8_byte(cp_old, 2'(k));
                  end
               end
               burst.count = {1'b0, n};
               nxt.mode  = MODE_TEXT;
               nxt.hex   = 1'b0;
               nxt.accum = '0;
               nxt.ovf   = 1'b0;
               tb = (in_byte != CH_SEMI);
            end
         end
         default: begin
            nxt.mode = MODE_TEXT;
            tb = 1'b1;
         end
      endcase

      if (tb) begin
         nxt.after_cr = 1'b0;
         if (!(cur.after_cr && in_byte == CH_LF)) begin
            if (in_byte == CH_AMP) begin
               nxt.mode = MODE_AMP;
            end else if (in_byte == CH_CR) begin
               burst.bytes[burst.count[2:0]] = CH_LF;
               burst.count = burst.count + 4'd1;
               nxt.after_cr = 1'b1;
            end else if (in_byte == CH_NUL) begin
               for (int k = 0; k < 3; k++) begin
                  burst.bytes[burst.count[2:0]] = utf8_byte(CP_REPL, 2'(k));
                  burst.count = burst.count + 4'd1;
               end
            end else begin
               burst.bytes[burst.count[2:0]] = in_byte;
               burst.count = burst.count + 4'd1;
            end
         end
      end

      if (is_last) begin
         // flush whatever the reference still holds
         case (nxt.mode)
            MODE_AMP: begin
               burst.bytes[burst.count[2:0]] = CH_AMP;
               burst.count = burst.count + 4'd1;
            end
            MODE_HASH: begin
               burst.bytes[burst.count[2:0]] = CH_AMP;
               burst.count = burst.count + 4'd1;
               burst.bytes[burst.count[2:0]] = CH_HASH;
               burst.count = burst.count + 4'd1;
            end
            MODE_HASHX: begin
               burst.bytes[burst.count[2:0]] = CH_AMP;
               burst.count = burst.count + 4'd1;
               burst.bytes[burst.count[2:0]] = CH_HASH;
               burst.count = burst.count + 4'd1;
               burst.bytes[burst.count[2:0]] = CH_LX;
               burst.count = burst.count + 4'd1;
            end
            MODE_DIGITS: begin
               cp_end = fix_code(nxt.accum, nxt.ovf);
               n = utf8_len(cp_end);
               for (int k = 0; k < 4; k++) begin
                  if (3'(k) < n) begin
                     burst.bytes[burst.count[2:0]] = utf8_byte(cp_end, 2'(k));
                     burst.count = burst.count + 4'd1;
                  end
               end
            end
            default: begin
               burst.count = burst.count;
            end
         endcase
         nxt = '0;
      end
   end

endmodule

[rtl/core/char_reference_text_decoder.sv]
`timescale 1ns / 1ps
// Top level of the character reference text decoder: scan state and result buffer.
// Depends on crtd_pkg, crtd_req_if, crtd_rsp_if and crtd_step.
//
// Usage:
//   req_port carries one raw text byte per word; is_last closes the text and
//   flushes any pending '&', '&#', '&#x' or digits.
//   rsp_port carries the decoded UTF-8 bytes, one per word, 0 to 7 words per
//   input byte. run_last marks the last word of an input byte, text_end the
//   last word of the text. An input byte that yields nothing and closes the
//   text gives one word with byte_valid low.
// Output: the first word of an input byte appears in the cycle after it is taken.
// Throughput: one input byte per cycle while each yields at most one word and
//   rsp_port.ready is high; an input byte yielding more words holds req_port.ready
//   low while the eight-entry result buffer drains one word per ready cycle.
// Stalls: the buffer holds its words while rsp_port.ready is low; req_port.ready
//   is high when the buffer is empty or its last word leaves in this cycle.
// Reset: synchronous; clears the scan state and empties the buffer.
module char_reference_text_decoder (
   input logic        clock,
   input logic        reset,
   crtd_req_if.sink   req_port,
   crtd_rsp_if.source rsp_port
);
   import crtd_pkg::*;

   crtd_state_type          state_ff;
   crtd_state_type          state_in;
   crtd_burst_type          burst;
   logic [BURST_N-1:0][7:0] buf_ff;
   logic [BURST_N-1:0][7:0] buf_in;
   logic [3:0]              cnt_ff;
   logic [3:0]              cnt_in;
   logic                    mark_ff;
   logic                    mark_in;
   logic                    last_ff;
   logic                    last_in;
   logic                    req_take;
   logic                    rsp_take;

   crtd_step u_step (
      .cur     (state_ff),
      .in_byte (req_port.in_byte),
      .is_last (req_port.is_last),
      .nxt     (state_in),
      .burst   (burst)
   );

   assign rsp_take       = rsp_port.valid && rsp_port.ready;
   assign req_port.ready = (cnt_ff == 4'd0) || (cnt_ff == 4'd1 && rsp_port.ready);
   assign req_take       = req_port.valid && req_port.ready;

   always_comb begin
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      mark_in = mark_ff;
      last_in = last_ff;
      if (rsp_take) begin
         for (int i = 0; i < BURST_N - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         cnt_in = cnt_ff - 4'd1;
      end
      if (req_take) begin
         buf_in  = burst.bytes;
         last_in = req_port.is_last;
         if (burst.count == 4'd0 && req_port.is_last) begin
            cnt_in  = 4'd1;
            mark_in = 1'b1;
         end else begin
            cnt_in  = burst.count;
            mark_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      mark_ff <= mark_in;
      last_ff <= last_in;
   end

   assign rsp_port.valid      = (cnt_ff != 4'd0);
   assign rsp_port.out_byte   = mark_ff ? 8'h00 : buf_ff[0];
   assign rsp_port.byte_valid = !mark_ff;
   assign rsp_port.run_last   = (cnt_ff == 4'd1);
   assign rsp_port.text_end   = (cnt_ff == 4'd1) && last_ff;

endmodule

[rtl/core/crtd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the character reference text decoder, bound to the top level.
// Depends on crtd_req_if and crtd_rsp_if through the bound top level.
module crtd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       byte_valid,
   input logic       run_last,
   input logic       text_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(run_last))
      else $error("result word changed while stalled");

   a_take_only_at_run_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || (run_last && rsp_ready))
      else $error("input taken while an earlier burst is still draining");

   a_marker_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byte_valid |-> run_last && text_end && out_byte == 8'h00)
      else $error("end marker outside the end of a text");

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && text_end |-> run_last)
      else $error("text end not on the last word of a burst");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word present straight after reset");

endmodule

bind char_reference_text_decoder crtd_checker u_crtd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .out_byte   (rsp_port.out_byte),
   .byte_valid (rsp_port.byte_valid),
   .run_last   (rsp_port.run_last),
   .text_end   (rsp_port.text_end)
);

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for char_reference_text_decoder: directed rows, then random
// texts of references, CR/LF runs and raw bytes, checked against a local decoder.
// Depends on crtd_pkg, crtd_req_if, crtd_rsp_if and the decoder RTL.
module tb;
   import crtd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       word_last;
      logic       text_last;
   } dec_word_t;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      dec_word_t  want;
   } stim_row_t;

   localparam logic [0:31][15:0] C1_REMAP = {
      16'h20ac, 16'h0081, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
      16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008d, 16'h017d, 16'h008f,
      16'h0090, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
      16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h009d, 16'h017e, 16'h0178
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   crtd_req_if req_ch ();
   crtd_rsp_if rsp_ch ();

   char_reference_text_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   always #5 clock = ~clock;

   dec_word_t  utf8_expected[$];
   logic [7:0] utf8_burst[$];
   logic [7:0] text_bytes[$];
   stim_row_t  stim_rows[$];
   int         err_count = 0;
   int         send_idle_pct = 0;
   int         rcv_idle_pct = 0;

   logic [2:0]  dec_mode = MODE_TEXT;
   logic        dec_hex = 1'b0;
   logic [20:0] dec_code = '0;
   logic        dec_ovf = 1'b0;
   logic        dec_cr = 1'b0;

   function automatic void emit_code(input logic [20:0] cp);
      if (cp <= 21'h7f) begin
         utf8_burst.push_back(cp[7:0]);
      end else if (cp <= 21'h7ff) begin
         utf8_burst.push_back({3'b110, cp[10:6]});
         utf8_burst.push_back({2'b10, cp[5:0]});
      end else if (cp <= 21'hffff) begin
         utf8_burst.push_back({4'b1110, cp[15:12]});
         utf8_burst.push_back({2'b10, cp[11:6]});
         utf8_burst.push_back({2'b10, cp[5:0]});
      end else begin
         utf8_burst.push_back({5'b11110, cp[20:18]});
         utf8_burst.push_back({2'b10, cp[17:12]});
         utf8_burst.push_back({2'b10, cp[11:6]});
         utf8_burst.push_back({2'b10, cp[5:0]});
      end
   endfunction

   function automatic int digit_of(input logic [7:0] b, input logic hex);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 48;
      if (hex && b >= 8'h61 && b <= 8'h66) return int'(b) - 87;
      if (hex && b >= 8'h41 && b <= 8'h46) return int'(b) - 55;
      return -1;
   endfunction

   function automatic void clear_reference();
      dec_mode = MODE_TEXT;
      dec_hex  = 1'b0;
      dec_code = '0;
      dec_ovf  = 1'b0;
   endfunction

   function automatic void close_reference();
      logic [20:0] cp;
      cp = dec_code;
      if (dec_ovf || cp == '0 || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
         cp = CP_REPL;
      end else if (cp >= CTRL_LO && cp <= CTRL_HI) begin
         cp = {5'b0, C1_REMAP[cp[4:0]]};
      end
      emit_code(cp);
      clear_reference();
   endfunction

   function automatic void add_digit(input int d);
      int radix;
      radix = dec_hex ? 16 : 10;
      if (dec_ovf) return;
      if (int'(dec_code) > CODE_MAX / radix) begin
         dec_ovf = 1'b1;
      end else begin
         dec_code = 21'(int'(dec_code) * radix + d);
      end
   endfunction

   function automatic void plain_byte(input logic [7:0] b);
      if (dec_cr && b == CH_LF) begin
         dec_cr = 1'b0;
         return;
      end
      dec_cr = 1'b0;
      if (b == CH_AMP) begin
         dec_mode = MODE_AMP;
      end else if (b == CH_CR) begin
         utf8_burst.push_back(CH_LF);
         dec_cr = 1'b1;
      end else if (b == CH_NUL) begin
         emit_code(CP_REPL);
      end else begin
         utf8_burst.push_back(b);
      end
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      int d;
      case (dec_mode)
         MODE_AMP: begin
            if (b == CH_HASH) begin
               dec_mode = MODE_HASH;
            end else begin
               utf8_burst.push_back(CH_AMP);
               dec_mode = MODE_TEXT;
               plain_byte(b);
            end
         end
         MODE_HASH: begin
            d = digit_of(b, 1'b0);
            if (b == CH_LX || b == CH_UX) begin
               dec_mode = MODE_HASHX;
               dec_hex  = 1'b1;
            end else if (d >= 0) begin
               clear_reference();
               dec_mode = MODE_DIGITS;
               add_digit(d);
            end else begin
               utf8_burst.push_back(CH_AMP);
               utf8_burst.push_back(CH_HASH);
               dec_mode = MODE_TEXT;
               plain_byte(b);
            end
         end
         MODE_HASHX: begin
            d = digit_of(b, 1'b1);
            if (d >= 0) begin
               dec_mode = MODE_DIGITS;
               dec_code = '0;
               dec_ovf  = 1'b0;
               add_digit(d);
            end else begin
               utf8_burst.push_back(CH_AMP);
               utf8_burst.push_back(CH_HASH);
               utf8_burst.push_back(CH_LX);
               dec_mode = MODE_TEXT;
               dec_hex  = 1'b0;
               plain_byte(b);
            end
         end
         MODE_DIGITS: begin
            d = digit_of(b, dec_hex);
            if (d >= 0) begin
               add_digit(d);
            end else begin
               close_reference();
               if (b != CH_SEMI) plain_byte(b);
            end
         end
         default: begin
            dec_mode = MODE_TEXT;
            plain_byte(b);
         end
      endcase
   endfunction

   function automatic void decode_text_byte(input logic [7:0] b, input logic last);
      utf8_burst.delete();
      scan_byte(b);
      if (last) begin
         case (dec_mode)
            MODE_AMP: utf8_burst.push_back(CH_AMP);
            MODE_HASH: begin
               utf8_burst.push_back(CH_AMP);
               utf8_burst.push_back(CH_HASH);
            end
            MODE_HASHX: begin
               utf8_burst.push_back(CH_AMP);
               utf8_burst.push_back(CH_HASH);
               utf8_burst.push_back(CH_LX);
            end
            MODE_DIGITS: close_reference();
            default: ;
         endcase
         clear_reference();
         dec_cr = 1'b0;
      end
   endfunction

   function automatic void store_burst(input logic last);
      int n;
      n = utf8_burst.size();
      if (n == 0 && last) utf8_expected.push_back({8'h00, 1'b0, 1'b1, 1'b1});
      for (int k = 0; k < n; k++) begin
         utf8_expected.push_back({utf8_burst[k], 1'b1, k == n - 1, (k == n - 1) && last});
      end
      utf8_burst.delete();
   endfunction

   function automatic void add_row(input logic [7:0] data, input logic last,
                                   input logic typed, input dec_word_t want);
      stim_rows.push_back({data, last, typed, want});
   endfunction

   function automatic void add_number(input int unsigned v, input logic hex);
      logic [7:0]  digs[$];
      logic [7:0]  c;
      int unsigned base;
      int unsigned d;
      int          pad;
      base = hex ? 16 : 10;
      do begin
         d = v % base;
         if (d < 10) begin
            c = 8'(8'h30 + d);
         end else if ($urandom_range(0, 1) != 0) begin
            c = 8'(8'h41 + d - 10);
         end else begin
            c = 8'(8'h61 + d - 10);
         end
         digs.push_front(c);
         v = v / base;
      end while (v != 0);
      pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (pad) text_bytes.push_back(8'h30);
      foreach (digs[i]) text_bytes.push_back(digs[i]);
   endfunction

   function automatic void add_reference();
      int unsigned cp;
      logic        hex;
      hex = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 8))
         0:       cp = 0;
         1:       cp = $urandom_range(32'h1, 32'h7f);
         2:       cp = $urandom_range(32'h80, 32'h9f);
         3:       cp = $urandom_range(32'ha0, 32'h7ff);
         4:       cp = $urandom_range(32'h800, 32'hffff);
         5:       cp = $urandom_range(32'hd800, 32'hdfff);
         6:       cp = $urandom_range(32'h10000, 32'h10ffff);
         7:       cp = $urandom_range(32'h110000, 32'h1fffff);
         default: cp = $urandom_range(32'h0200_0000, 32'hffff_ffff);
      endcase
      text_bytes.push_back(CH_AMP);
      text_bytes.push_back(CH_HASH);
      if (hex) text_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
      add_number(cp, hex);
      if ($urandom_range(0, 9) < 6) text_bytes.push_back(CH_SEMI);
   endfunction

   function automatic void add_token();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) begin
         add_reference();
      end else if (k < 60) begin
         text_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (k < 70) begin
         text_bytes.push_back(CH_CR);
         if ($urandom_range(0, 1) != 0) text_bytes.push_back(CH_LF);
      end else if (k < 75) begin
         text_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_NUL : CH_LF);
      end else if (k < 85) begin
         text_bytes.push_back(CH_AMP);
         k = $urandom_range(0, 2);
         if (k > 0) text_bytes.push_back(CH_HASH);
         if (k > 1) text_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
         if ($urandom_range(0, 1) != 0) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) text_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
      end
   endfunction

   task automatic send_row(input stim_row_t r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= r.data;
      req_ch.is_last <= r.last;
      do @(posedge clock); while (!req_ch.ready);
      decode_text_byte(r.data, r.last);
      if (r.typed) begin
         utf8_burst.delete();
         utf8_expected.push_back(r.want);
      end else begin
         store_burst(r.last);
      end
   endtask

   task automatic report_error(input string what, input dec_word_t want, input dec_word_t got);
      err_count++;
      if (err_count <= 10) begin
         $display("ERROR %s: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b", what,
                  want.data, want.has_byte, want.word_last, want.text_last,
                  got.data, got.has_byte, got.word_last, got.text_last);
      end
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      dec_word_t got;
      dec_word_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.run_last, rsp_ch.text_end};
         if (utf8_expected.size() == 0) begin
            report_error("unexpected word", '0, got);
         end else begin
            want = utf8_expected.pop_front();
            if (got.data !== want.data || got.has_byte !== want.has_byte ||
                got.word_last !== want.word_last || got.text_last !== want.text_last) begin
               report_error("mismatch", want, got);
            end
         end
      end
   end

   initial begin
      int total;
      int ph;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= 8'h00;
      req_ch.is_last <= 1'b0;

      //      byte   last  typed  expected word {byte, valid, run_last, text_end}
      add_row(8'h41, 1'b0, 1'b1, {8'h41, 1'b1, 1'b1, 1'b0});
      add_row(8'hff, 1'b0, 1'b1, {8'hff, 1'b1, 1'b1, 1'b0});
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h0d, 1'b0, 1'b1, {8'h0a, 1'b1, 1'b1, 1'b0});
      add_row(8'h0a, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1});
      add_row(8'h26, 1'b0, 1'b0, '0);
      add_row(8'h71, 1'b0, 1'b0, '0);
      add_row(8'h26, 1'b0, 1'b0, '0);
      add_row(8'h23, 1'b0, 1'b0, '0);
      add_row(8'h58, 1'b0, 1'b0, '0);
      add_row(8'h31, 1'b0, 1'b0, '0);
      add_row(8'h46, 1'b0, 1'b0, '0);
      add_row(8'h36, 1'b0, 1'b0, '0);
      add_row(8'h30, 1'b0, 1'b0, '0);
      add_row(8'h30, 1'b0, 1'b0, '0);
      add_row(8'h3b, 1'b0, 1'b0, '0);
      add_row(8'h26, 1'b0, 1'b0, '0);
      add_row(8'h23, 1'b0, 1'b0, '0);
      add_row(8'h35, 1'b0, 1'b0, '0);
      add_row(8'h35, 1'b0, 1'b0, '0);
      add_row(8'h32, 1'b0, 1'b0, '0);
      add_row(8'h39, 1'b0, 1'b0, '0);
      add_row(8'h36, 1'b0, 1'b0, '0);
      add_row(8'h5a, 1'b0, 1'b0, '0);
      add_row(8'h0d, 1'b1, 1'b1, {8'h0a, 1'b1, 1'b1, 1'b1});
      add_row(8'h0a, 1'b0, 1'b1, {8'h0a, 1'b1, 1'b1, 1'b0});
      add_row(8'h26, 1'b0, 1'b0, '0);
      add_row(8'h23, 1'b1, 1'b0, '0);

      while (stim_rows.size() < 260) begin
         text_bytes.delete();
         repeat ($urandom_range(1, 6)) add_token();
         foreach (text_bytes[i]) begin
            add_row(text_bytes[i], i == text_bytes.size() - 1, 1'b0, '0);
         end
      end
      total = stim_rows.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         ph = (i * 3) / total;
         send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 71 : 0;
         rcv_idle_pct  = (ph == 0) ? 71 : (ph == 1) ? 25 : 0;
         send_row(stim_rows[i]);
      end
      req_ch.valid <= 1'b0;

      while (utf8_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
